@@ rtl/core/mqss_pkg.sv @@
// Shared constants, types and helpers of the multilevel queue slot scheduler.
package mqss_pkg;

  localparam int NUM_PRIO    = 8;
  localparam int QUEUE_DEPTH = 16;

  localparam int ID_W   = 16;
  localparam int PRIO_W = 3;
  localparam int STAT_W = 2;

  localparam int LVL_W = (NUM_PRIO > 1) ? $clog2(NUM_PRIO) : 1;
  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int BUD_W = $clog2(NUM_PRIO + 1);
  localparam int ADR_W = LVL_W + PTR_W;

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_DEQUEUE = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_ENQUEUED = 2'd0,
    ST_DISPATCH = 2'd1,
    ST_NOTREADY = 2'd2,
    ST_DROPPED  = 2'd3
  } status_t;

  typedef struct packed {
    logic cap;
    logic exec;
    logic load;
  } mqss_cmd_t;

  typedef struct packed {
    logic out_stall;
  } mqss_sts_t;

  function automatic logic [BUD_W-1:0] budget_init(input int lvl);
    return BUD_W'(NUM_PRIO - lvl);
  endfunction

endpackage

@@ rtl/core/mqss_if.sv @@
// Valid/ready channel interfaces for scheduler requests and results.
interface mqss_in_if;
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic [mqss_pkg::ID_W-1:0]    task_id;
  logic [mqss_pkg::PRIO_W-1:0]  task_prio;

  modport source (output valid, output opcode, output task_id, output task_prio,
                  input ready);
  modport sink   (input valid, input opcode, input task_id, input task_prio,
                  output ready);
endinterface

interface mqss_out_if;
  logic                         valid;
  logic                         ready;
  logic [mqss_pkg::STAT_W-1:0]  status;
  logic [mqss_pkg::ID_W-1:0]    out_task_id;
  logic [mqss_pkg::PRIO_W-1:0]  out_prio;

  modport source (output valid, output status, output out_task_id, output out_prio,
                  input ready);
  modport sink   (input valid, input status, input out_task_id, input out_prio,
                  output ready);
endinterface

@@ rtl/core/multilevel_queue_slot_scheduler.sv @@
// Top level of the multilevel queue slot scheduler.
// An accepted request is captured, executed and then loaded into the output register;
// the load step waits while the output is stalled. The controller takes no new request
// until the capture, execute and load steps of the current one are done.
// A waiting result does not block the next request; it only holds the load step.
// Reset (synchronous, active low) empties all queues and restores every budget.
module multilevel_queue_slot_scheduler (
  input  logic       clk,
  input  logic       rst_n,
  mqss_in_if.sink    in_if,
  mqss_out_if.source out_if
);

  mqss_pkg::mqss_cmd_t cmd;
  mqss_pkg::mqss_sts_t sts;

  mqss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mqss_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_opcode    (in_if.opcode),
    .in_task_id   (in_if.task_id),
    .in_task_prio (in_if.task_prio),
    .out_valid    (out_if.valid),
    .out_ready    (out_if.ready),
    .out_status   (out_if.status),
    .out_task_id  (out_if.out_task_id),
    .out_prio     (out_if.out_prio)
  );

endmodule

@@ rtl/core/mqss_ctrl.sv @@
// Sequencing state machine of the scheduler: capture, execute, load result.
module mqss_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mqss_pkg::mqss_sts_t sts,
  output mqss_pkg::mqss_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LOAD
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (!sts.out_stall) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/core/mqss_dp.sv @@
// Datapath of the scheduler: per-level queue state, task store and result register.
module mqss_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mqss_pkg::mqss_cmd_t            cmd,
  output mqss_pkg::mqss_sts_t            sts,
  input  logic                           in_opcode,
  input  logic [mqss_pkg::ID_W-1:0]      in_task_id,
  input  logic [mqss_pkg::PRIO_W-1:0]    in_task_prio,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [mqss_pkg::STAT_W-1:0]    out_status,
  output logic [mqss_pkg::ID_W-1:0]      out_task_id,
  output logic [mqss_pkg::PRIO_W-1:0]    out_prio
);

  localparam int MEM_DEPTH = 2 ** mqss_pkg::ADR_W;

  logic                          opcode_r;
  logic [mqss_pkg::ID_W-1:0]     id_r;
  logic [mqss_pkg::LVL_W-1:0]    lvl_r;

  logic [mqss_pkg::PTR_W-1:0]    head_r   [mqss_pkg::NUM_PRIO];
  logic [mqss_pkg::PTR_W-1:0]    tail_r   [mqss_pkg::NUM_PRIO];
  logic [mqss_pkg::CNT_W-1:0]    fill_r   [mqss_pkg::NUM_PRIO];
  logic [mqss_pkg::BUD_W-1:0]    budget_r [mqss_pkg::NUM_PRIO];

  logic [mqss_pkg::ID_W-1:0]     mem      [MEM_DEPTH];
  logic [mqss_pkg::ID_W-1:0]     rdata_r;

  mqss_pkg::status_t             res_status_r;
  mqss_pkg::status_t             res_status_nxt;
  logic [mqss_pkg::LVL_W-1:0]    res_lvl_r;

  logic                          out_valid_r;
  logic [mqss_pkg::STAT_W-1:0]   out_status_r;
  logic [mqss_pkg::ID_W-1:0]     out_id_r;
  logic [mqss_pkg::PRIO_W-1:0]   out_prio_r;

  logic [mqss_pkg::NUM_PRIO-1:0] nonempty;
  logic [mqss_pkg::NUM_PRIO-1:0] eligible;
  logic                          any_wait;
  logic                          any_elig;
  logic [mqss_pkg::LVL_W-1:0]    pick_elig;
  logic [mqss_pkg::LVL_W-1:0]    pick_wait;
  logic [mqss_pkg::LVL_W-1:0]    pick_lvl;
  logic [mqss_pkg::LVL_W-1:0]    op_lvl;
  logic [mqss_pkg::LVL_W-1:0]    in_lvl;
  logic [mqss_pkg::CNT_W-1:0]    op_fill;
  logic [mqss_pkg::PTR_W-1:0]    op_head;
  logic [mqss_pkg::PTR_W-1:0]    op_tail;
  logic                          op_full;
  logic                          do_enq;
  logic                          do_deq;

  function automatic logic [mqss_pkg::PTR_W-1:0] ptr_inc(
    input logic [mqss_pkg::PTR_W-1:0] p
  );
    if (p == mqss_pkg::PTR_W'(mqss_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + mqss_pkg::PTR_W'(1);
  endfunction

  always_comb begin
    if (32'(in_task_prio) >= mqss_pkg::NUM_PRIO) begin
      in_lvl = mqss_pkg::LVL_W'(mqss_pkg::NUM_PRIO - 1);
    end else begin
      in_lvl = mqss_pkg::LVL_W'(in_task_prio);
    end
  end

  always_comb begin
    for (int i = 0; i < mqss_pkg::NUM_PRIO; i++) begin
      nonempty[i] = (fill_r[i] != '0);
      eligible[i] = nonempty[i] && (budget_r[i] != '0);
    end
    any_wait  = |nonempty;
    any_elig  = |eligible;
    pick_elig = '0;
    pick_wait = '0;
    for (int i = mqss_pkg::NUM_PRIO - 1; i >= 0; i--) begin
      if (eligible[i]) pick_elig = mqss_pkg::LVL_W'(i);
      if (nonempty[i]) pick_wait = mqss_pkg::LVL_W'(i);
    end
    pick_lvl = any_elig ? pick_elig : pick_wait;
    op_lvl   = (opcode_r == mqss_pkg::OP_DEQUEUE) ? pick_lvl : lvl_r;
    op_fill  = fill_r[op_lvl];
    op_head  = head_r[op_lvl];
    op_tail  = tail_r[op_lvl];
    op_full  = (op_fill >= mqss_pkg::CNT_W'(mqss_pkg::QUEUE_DEPTH));
    do_enq   = cmd.exec && (opcode_r == mqss_pkg::OP_ENQUEUE) && !op_full;
    do_deq   = cmd.exec && (opcode_r == mqss_pkg::OP_DEQUEUE) && any_wait;
    if (opcode_r == mqss_pkg::OP_ENQUEUE) begin
      res_status_nxt = op_full ? mqss_pkg::ST_DROPPED : mqss_pkg::ST_ENQUEUED;
    end else begin
      res_status_nxt = any_wait ? mqss_pkg::ST_DISPATCH : mqss_pkg::ST_NOTREADY;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      opcode_r <= in_opcode;
      id_r     <= in_task_id;
      lvl_r    <= in_lvl;
    end
    if (cmd.exec) begin
      res_status_r <= res_status_nxt;
      res_lvl_r    <= op_lvl;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mqss_pkg::NUM_PRIO; i++) begin
        head_r[i]   <= '0;
        tail_r[i]   <= '0;
        fill_r[i]   <= '0;
        budget_r[i] <= mqss_pkg::budget_init(i);
      end
    end else begin
      if (do_enq) begin
        tail_r[op_lvl] <= ptr_inc(op_tail);
        fill_r[op_lvl] <= op_fill + mqss_pkg::CNT_W'(1);
      end
      if (do_deq) begin
        head_r[op_lvl] <= ptr_inc(op_head);
        fill_r[op_lvl] <= op_fill - mqss_pkg::CNT_W'(1);
        for (int i = 0; i < mqss_pkg::NUM_PRIO; i++) begin
          if (i == int'(op_lvl)) begin
            if (any_elig) begin
              budget_r[i] <= budget_r[i] - mqss_pkg::BUD_W'(1);
            end else begin
              budget_r[i] <= mqss_pkg::budget_init(i) - mqss_pkg::BUD_W'(1);
            end
          end else if (!any_elig) begin
            budget_r[i] <= mqss_pkg::budget_init(i);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_enq) begin
      mem[{op_lvl, op_tail}] <= id_r;
    end
    if (do_deq) begin
      rdata_r <= mem[{op_lvl, op_head}];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_status_r <= res_status_r;
      if (res_status_r == mqss_pkg::ST_DISPATCH) begin
        out_id_r   <= rdata_r;
        out_prio_r <= mqss_pkg::PRIO_W'(res_lvl_r);
      end else begin
        out_id_r   <= '0;
        out_prio_r <= '0;
      end
    end
  end

  assign sts.out_stall = out_valid_r && !out_ready;
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_task_id   = out_id_r;
  assign out_prio      = out_prio_r;

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> out_valid_r)
    else $error("result register not loaded");

  a_dispatch_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && (opcode_r == mqss_pkg::OP_DEQUEUE) && any_wait
      |=> res_status_r == mqss_pkg::ST_DISPATCH)
    else $error("waiting task not dispatched");

  a_enqueue_counts: assert property (@(posedge clk) disable iff (!rst_n)
    do_enq |=> fill_r[$past(op_lvl)] == $past(op_fill) + mqss_pkg::CNT_W'(1))
    else $error("fill count not advanced on enqueue");

  a_no_load_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !cmd.load)
    else $error("result overwritten while waiting");

endmodule
